// ----- rtl/fppe_pkg.sv -----
// ----------------------------------------------------------------------------
// fppe_pkg
// Shared constants, types and tables of the fourth-power phase estimator.
// ----------------------------------------------------------------------------
package fppe_pkg;

	localparam int BLOCK_LOG    = 13;
	localparam int BLOCK_LEN    = 1 << BLOCK_LOG;
	localparam int CNT_W        = BLOCK_LOG;
	localparam int PHASE_BITS   = 13;
	localparam int CORDIC_STEPS = 20;
	localparam int SUM_W        = 46;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	localparam logic [PHASE_BITS-1:0] STEP_RESET = PHASE_BITS'(1851);
	localparam logic [PADDR_W-1:0]    ADDR_PHASE_STEP = PADDR_W'(0);

	typedef struct packed {
		logic signed [SUM_W-1:0] sum_cos;
		logic signed [SUM_W-1:0] sum_sin;
	} sums_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_PREP,
		B_RUN,
		B_DONE
	} back_state_t;

	// arctan(2^-i) in 2^-32 turn units
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0:    a = 32'd536870912;
			5'd1:    a = 32'd316933406;
			5'd2:    a = 32'd167458907;
			5'd3:    a = 32'd85004756;
			5'd4:    a = 32'd42667331;
			5'd5:    a = 32'd21354465;
			5'd6:    a = 32'd10679838;
			5'd7:    a = 32'd5340245;
			5'd8:    a = 32'd2670163;
			5'd9:    a = 32'd1335087;
			5'd10:   a = 32'd667544;
			5'd11:   a = 32'd333772;
			5'd12:   a = 32'd166886;
			5'd13:   a = 32'd83443;
			5'd14:   a = 32'd41722;
			5'd15:   a = 32'd20861;
			5'd16:   a = 32'd10430;
			5'd17:   a = 32'd5215;
			5'd18:   a = 32'd2608;
			5'd19:   a = 32'd1304;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

	// Q1.15 amplitude levels
	function automatic logic signed [15:0] level_q15(input logic [1:0] sel);
		logic signed [15:0] l;
		case (sel)
			2'd0:    l = 16'sd10922;
			2'd1:    l = -16'sd32768;
			2'd2:    l = -16'sd10922;
			default: l = 16'sd32767;
		endcase
		return l;
	endfunction

endpackage

// ----- rtl/fourth_power_phase_estimator_top.sv -----
// Flow: the last sample of a frame passes through the sample pipeline into the queue,
// then through square root and angle in the back end into the result register.
// Throughput: one sample per cycle while the queue is not full; full is also held
// after the last sample of a frame while the window is flushed.
// Reset: arst_n clears counters, sums, queue and result valid; phase_step
// returns to 1851.
// ----------------------------------------------------------------------------
// fourth_power_phase_estimator_top
// Fourth-power carrier phase estimator with APB configuration.
// ----------------------------------------------------------------------------
module fourth_power_phase_estimator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    sample_byte,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [31:0]            mean_cos,
	output logic signed [31:0]            mean_sin,
	output logic [30:0]                   amplitude,
	output logic signed [15:0]            phase_angle,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fppe_pkg::PADDR_W-1:0]  paddr,
	input  logic [fppe_pkg::PDATA_W-1:0]  pwdata,
	output logic [fppe_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import fppe_pkg::*;

	logic [PHASE_BITS-1:0] phase_step_q;
	logic                  q_push, q_full, q_pop, q_empty;
	sums_t                 q_wdata, q_rdata;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= STEP_RESET;
		end else if (psel && penable && pwrite && (paddr == ADDR_PHASE_STEP)) begin
			phase_step_q <= pwdata[PHASE_BITS-1:0];
		end
	end

	assign prdata = (paddr == ADDR_PHASE_STEP) ? PDATA_W'(phase_step_q) : '0;

	fppe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.sample_byte (sample_byte),
		.phase_step  (phase_step_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wdata)
	);

	fppe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	fppe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.mean_cos    (mean_cos),
		.mean_sin    (mean_sin),
		.amplitude   (amplitude),
		.phase_angle (phase_angle)
	);

endmodule

// ----- rtl/fppe_front.sv -----
// ----------------------------------------------------------------------------
// fppe_front
// Sample pipeline: NCO CORDIC, mixing, 8-tap average, fourth power, frame sums.
// ----------------------------------------------------------------------------
module fppe_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       sample_byte,
	input  logic [fppe_pkg::PHASE_BITS-1:0]  phase_step,
	input  logic                             q_full,
	output logic                             q_push,
	output fppe_pkg::sums_t                  q_data
);
	import fppe_pkg::*;

	localparam int CX_W = 34;
	localparam int NST  = CORDIC_STEPS;

	typedef struct packed {
		logic [1:0] lev;
		logic       flip;
		logic       first;
		logic       last;
		logic       acc;
	} meta_t;

	logic                  adv, adv_up, accept;
	logic [CNT_W-1:0]      cnt_q;
	logic [PHASE_BITS-1:0] phase_q;
	meta_t                 m_in;
	logic [31:0]           u_in;
	logic [31:0]           u_fl;

	// CORDIC stages
	logic                   cv_q [0:NST];
	meta_t                  cm_q [0:NST];
	logic signed [CX_W-1:0] cx_q [0:NST];
	logic signed [CX_W-1:0] cy_q [0:NST];
	logic signed [CX_W-1:0] cz_q [0:NST];
	logic signed [CX_W-1:0] nx [0:NST-1];
	logic signed [CX_W-1:0] ny [0:NST-1];
	logic signed [CX_W-1:0] nz [0:NST-1];

	// trig, rotation
	logic                   v_s1, v_s2;
	meta_t                  m_s1, m_s2;
	logic signed [15:0]     cs_s1, sn_s1;
	logic signed [17:0]     rc_s2, rs_s2;
	logic signed [CX_W-1:0] xf, yf, rx, ry;
	logic signed [15:0]     cs_d, sn_d, lev16;
	logic signed [31:0]     pc, ps, rcw, rsw;
	logic signed [17:0]     rc_d, rs_d;

	// window
	logic signed [17:0] win_c_q [0:7];
	logic signed [17:0] win_s_q [0:7];
	logic [1:0]         rep_q;
	logic               wv_q, wlast_q;

	// average, square, products, fourth power
	logic               v_s3, last_s3, v_s4, last_s4, v_s5, last_s5, v_s6, last_s6;
	logic signed [20:0] sc, ss;
	logic signed [17:0] ac_s3, as_s3;
	logic signed [36:0] paa, pbb, pab;
	logic signed [32:0] c2_s4, s2_s4;
	logic signed [67:0] pcc_s5, pss_s5, pcs_s5;
	logic signed [67:0] dc, rc4, rs4;
	logic signed [31:0] c4_s6, s4_s6, c4_d, s4_d;
	logic signed [SUM_W-1:0] sum_cos_q, sum_sin_q, nsum_c, nsum_s;

	assign adv    = !(v_s6 && last_s6 && q_full);
	assign adv_up = adv && (rep_q == 2'd0);
	assign full   = !adv_up;
	assign accept = push && adv_up;

	// ---- sample counter and oscillator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			phase_q <= '0;
		end else if (accept) begin
			if (cnt_q == CNT_W'(BLOCK_LEN - 1)) begin
				cnt_q   <= '0;
				phase_q <= '0;
			end else begin
				cnt_q   <= cnt_q + CNT_W'(1);
				phase_q <= phase_q + phase_step;
			end
		end
	end

	// fold the phase into the right half-plane
	always_comb begin
		u_in       = {phase_q, {(32-PHASE_BITS){1'b0}}};
		m_in.lev   = sample_byte[3:2];
		m_in.flip  = u_in[31] ^ u_in[30];
		m_in.first = (cnt_q == '0);
		m_in.last  = (cnt_q == CNT_W'(BLOCK_LEN - 1));
		m_in.acc   = (cnt_q >= CNT_W'(3));
		u_fl       = {u_in[31] ^ m_in.flip, u_in[30:0]};
	end

	always_comb begin
		for (int k = 0; k < NST; k++) begin
			if (!cz_q[k][CX_W-1]) begin
				nx[k] = cx_q[k] - (cy_q[k] >>> k);
				ny[k] = cy_q[k] + (cx_q[k] >>> k);
				nz[k] = cz_q[k] - signed'({2'b00, atan_turn(5'(k))});
			end else begin
				nx[k] = cx_q[k] + (cy_q[k] >>> k);
				ny[k] = cy_q[k] - (cx_q[k] >>> k);
				nz[k] = cz_q[k] + signed'({2'b00, atan_turn(5'(k))});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NST; k++) cv_q[k] <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv_up) begin
			cv_q[0] <= accept;
			for (int k = 0; k < NST; k++) cv_q[k+1] <= cv_q[k];
			v_s1 <= cv_q[NST];
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_up) begin
			cm_q[0] <= m_in;
			cx_q[0] <= CX_W'(652032874);
			cy_q[0] <= '0;
			cz_q[0] <= {{(CX_W-32){u_fl[31]}}, u_fl};
			for (int k = 0; k < NST; k++) begin
				cm_q[k+1] <= cm_q[k];
				cx_q[k+1] <= nx[k];
				cy_q[k+1] <= ny[k];
				cz_q[k+1] <= nz[k];
			end
			m_s1  <= cm_q[NST];
			cs_s1 <= cs_d;
			sn_s1 <= sn_d;
			m_s2  <= m_s1;
			rc_s2 <= rc_d;
			rs_s2 <= rs_d;
		end
	end

	// round to Q1.15 and saturate
	always_comb begin
		xf = cm_q[NST].flip ? -cx_q[NST] : cx_q[NST];
		yf = cm_q[NST].flip ? -cy_q[NST] : cy_q[NST];
		rx = (xf + CX_W'(16384)) >>> 15;
		ry = (yf + CX_W'(16384)) >>> 15;
		if (rx > CX_W'(32767))       cs_d = 16'sd32767;
		else if (rx < -CX_W'(32768)) cs_d = -16'sd32768;
		else                         cs_d = rx[15:0];
		if (ry > CX_W'(32767))       sn_d = 16'sd32767;
		else if (ry < -CX_W'(32768)) sn_d = -16'sd32768;
		else                         sn_d = ry[15:0];
	end

	// mix level with oscillator, Q1.17
	always_comb begin
		lev16 = level_q15(m_s1.lev);
		pc    = lev16 * cs_s1;
		ps    = lev16 * sn_s1;
		rcw   = (pc + 32'sd4096) >>> 13;
		rsw   = (ps + 32'sd4096) >>> 13;
		if (rcw > 32'sd131071)       rc_d = 18'sd131071;
		else if (rcw < -32'sd131072) rc_d = -18'sd131072;
		else                         rc_d = rcw[17:0];
		if (rsw > 32'sd131071)       rs_d = 18'sd131071;
		else if (rsw < -32'sd131072) rs_d = -18'sd131072;
		else                         rs_d = rsw[17:0];
	end

	// ---- window; the last sample of a frame is repeated three more times
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q   <= 2'd0;
			wv_q    <= 1'b0;
			wlast_q <= 1'b0;
		end else if (adv) begin
			if (rep_q != 2'd0) begin
				rep_q   <= rep_q - 2'd1;
				wv_q    <= 1'b1;
				wlast_q <= (rep_q == 2'd1);
			end else if (v_s2) begin
				rep_q   <= m_s2.last ? 2'd3 : 2'd0;
				wv_q    <= m_s2.acc;
				wlast_q <= 1'b0;
			end else begin
				wv_q    <= 1'b0;
				wlast_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (rep_q != 2'd0) begin
				for (int i = 0; i < 7; i++) begin
					win_c_q[i] <= win_c_q[i+1];
					win_s_q[i] <= win_s_q[i+1];
				end
			end else if (v_s2) begin
				if (m_s2.first) begin
					for (int i = 0; i < 8; i++) begin
						win_c_q[i] <= rc_s2;
						win_s_q[i] <= rs_s2;
					end
				end else begin
					for (int i = 0; i < 7; i++) begin
						win_c_q[i] <= win_c_q[i+1];
						win_s_q[i] <= win_s_q[i+1];
					end
					win_c_q[7] <= rc_s2;
					win_s_q[7] <= rs_s2;
				end
			end
		end
	end

	// ---- average, square, fourth power
	always_comb begin
		sc = '0;
		ss = '0;
		for (int i = 0; i < 8; i++) begin
			sc = sc + 21'(win_c_q[i]);
			ss = ss + 21'(win_s_q[i]);
		end
		paa = 37'(ac_s3) * 37'(ac_s3);
		pbb = 37'(as_s3) * 37'(as_s3);
		pab = 37'(ac_s3) * 37'(as_s3);
		dc  = pcc_s5 - pss_s5;
		rc4 = (dc + 68'sd536870912) >>> 30;
		rs4 = ((pcs_s5 <<< 1) + 68'sd536870912) >>> 30;
		if (rc4 > 68'sd1073741824)       c4_d = 32'sd1073741824;
		else if (rc4 < -68'sd1073741824) c4_d = -32'sd1073741824;
		else                             c4_d = rc4[31:0];
		if (rs4 > 68'sd1073741824)       s4_d = 32'sd1073741824;
		else if (rs4 < -68'sd1073741824) s4_d = -32'sd1073741824;
		else                             s4_d = rs4[31:0];
		nsum_c = sum_cos_q + SUM_W'(c4_s6);
		nsum_s = sum_sin_q + SUM_W'(s4_s6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0; last_s3 <= 1'b0;
			v_s4 <= 1'b0; last_s4 <= 1'b0;
			v_s5 <= 1'b0; last_s5 <= 1'b0;
			v_s6 <= 1'b0; last_s6 <= 1'b0;
			sum_cos_q <= '0;
			sum_sin_q <= '0;
		end else if (adv) begin
			v_s3 <= wv_q;  last_s3 <= wlast_q;
			v_s4 <= v_s3;  last_s4 <= last_s3;
			v_s5 <= v_s4;  last_s5 <= last_s4;
			v_s6 <= v_s5;  last_s6 <= last_s5;
			if (v_s6) begin
				if (last_s6) begin
					sum_cos_q <= '0;
					sum_sin_q <= '0;
				end else begin
					sum_cos_q <= nsum_c;
					sum_sin_q <= nsum_s;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ac_s3  <= 18'((sc + 21'sd4) >>> 3);
			as_s3  <= 18'((ss + 21'sd4) >>> 3);
			c2_s4  <= 33'((paa - pbb + 37'sd8) >>> 4);
			s2_s4  <= 33'(((pab <<< 1) + 37'sd8) >>> 4);
			pcc_s5 <= 68'(c2_s4) * 68'(c2_s4);
			pss_s5 <= 68'(s2_s4) * 68'(s2_s4);
			pcs_s5 <= 68'(c2_s4) * 68'(s2_s4);
			c4_s6  <= c4_d;
			s4_s6  <= s4_d;
		end
	end

	assign q_push         = v_s6 && last_s6 && !q_full;
	assign q_data.sum_cos = nsum_c;
	assign q_data.sum_sin = nsum_s;

endmodule

// ----- rtl/fppe_queue.sv -----
// ----------------------------------------------------------------------------
// fppe_queue
// Two-entry queue of frame sums between the sample pipeline and the back end.
// ----------------------------------------------------------------------------
module fppe_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fppe_pkg::sums_t wdata,
	output logic            full,
	input  logic            pop,
	output fppe_pkg::sums_t rdata,
	output logic            empty
);
	import fppe_pkg::*;

	sums_t      mem_q [0:1];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop)  rd_q <= ~rd_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

endmodule

// ----- rtl/fppe_back.sv -----
// ----------------------------------------------------------------------------
// fppe_back
// Frame-end work: means, iterative square root and CORDIC angle, result register.
// ----------------------------------------------------------------------------
module fppe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  fppe_pkg::sums_t    q_rdata,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] mean_cos,
	output logic signed [31:0] mean_sin,
	output logic [30:0]        amplitude,
	output logic signed [15:0] phase_angle
);
	import fppe_pkg::*;

	localparam int SQ_STEPS = 31;

	back_state_t state_q, state_d;

	logic signed [31:0] mc_q, ms_q;
	logic [61:0]        v_q, r_q, bitv, trial;
	logic signed [33:0] cx_q, cy_q, dx, dy;
	logic [31:0]        cz_q, zr;
	logic               zero_q;
	logic [4:0]         it_q;
	logic               ovld_q, load_out;
	logic signed [63:0] pmc, pms;

	function automatic logic signed [31:0] frame_mean(input logic signed [SUM_W-1:0] s);
		logic [SUM_W-1:0] mag;
		logic [SUM_W:0]   q;
		logic [31:0]      m;
		mag = s[SUM_W-1] ? 46'(-s) : 46'(s);
		q   = ({1'b0, mag} + (SUM_W+1)'(BLOCK_LEN / 2)) >> BLOCK_LOG;
		m   = (q > (SUM_W+1)'(1073741824)) ? 32'd1073741824 : q[31:0];
		return s[SUM_W-1] ? -signed'(m) : signed'(m);
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:  if (!q_empty) state_d = B_PREP;
			B_PREP:  state_d = B_RUN;
			B_RUN:   if (it_q == 5'(SQ_STEPS - 1)) state_d = B_DONE;
			B_DONE:  if (!ovld_q || pop) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			B_IDLE:  q_pop = !q_empty;
			B_DONE:  load_out = !ovld_q || pop;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)         ovld_q <= 1'b1;
			else if (pop)         ovld_q <= 1'b0;
		end
	end

	always_comb begin
		pmc   = mc_q * mc_q;
		pms   = ms_q * ms_q;
		bitv  = 62'd1 << (6'd60 - {it_q, 1'b0});
		trial = r_q + bitv;
		dx    = cy_q >>> it_q;
		dy    = cx_q >>> it_q;
		zr    = cz_q + 32'h0000_8000;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				mc_q <= frame_mean(q_rdata.sum_cos);
				ms_q <= frame_mean(q_rdata.sum_sin);
			end
			B_PREP: begin
				v_q    <= 62'(pmc) + 62'(pms);
				r_q    <= '0;
				it_q   <= '0;
				zero_q <= (mc_q == '0) && (ms_q == '0);
				if (mc_q[31]) begin
					cx_q <= -34'(mc_q);
					cy_q <= -34'(ms_q);
					cz_q <= 32'h8000_0000;
				end else begin
					cx_q <= 34'(mc_q);
					cy_q <= 34'(ms_q);
					cz_q <= 32'h0;
				end
			end
			B_RUN: begin
				it_q <= it_q + 5'd1;
				if (v_q >= trial) begin
					v_q <= v_q - trial;
					r_q <= (r_q >> 1) + bitv;
				end else begin
					r_q <= r_q >> 1;
				end
				if (it_q < 5'(CORDIC_STEPS)) begin
					if (cy_q > 34'sd0) begin
						cx_q <= cx_q + dx;
						cy_q <= cy_q - dy;
						cz_q <= cz_q + atan_turn(it_q);
					end else begin
						cx_q <= cx_q - dx;
						cy_q <= cy_q + dy;
						cz_q <= cz_q - atan_turn(it_q);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			mean_cos    <= mc_q;
			mean_sin    <= ms_q;
			amplitude   <= r_q[30:0];
			phase_angle <= zero_q ? 16'sd0 : signed'(zr[31:16]);
		end
	end

	assign empty = !ovld_q;

endmodule

// ----- rtl/fppe_checker.sv -----
// ----------------------------------------------------------------------------
// fppe_checker
// Port-level checks of the phase estimator, bound to the top level.
// ----------------------------------------------------------------------------
module fppe_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          empty,
	input logic                          pop,
	input logic signed [31:0]            mean_cos,
	input logic signed [31:0]            mean_sin,
	input logic [30:0]                   amplitude,
	input logic signed [15:0]            phase_angle,
	input logic                          pready
);
	import fppe_pkg::*;

	// a waiting beat stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result beat dropped before pop");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(mean_cos) && $stable(mean_sin) &&
		$stable(amplitude) && $stable(phase_angle))
		else $error("result beat changed while waiting");

	// means are saturated to one in Q2.30
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (mean_cos <= 32'sd1073741824) && (mean_cos >= -32'sd1073741824) &&
		(mean_sin <= 32'sd1073741824) && (mean_sin >= -32'sd1073741824))
		else $error("mean out of range");

	// magnitude of a vector with saturated parts stays below sqrt(2)
	a_amp_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> amplitude <= 31'd1518500250)
		else $error("amplitude out of range");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind fourth_power_phase_estimator_top fppe_checker u_fppe_checker (.*);

// ----- dv/fourth_power_phase_estimator_top_tb.sv -----
// ----------------------------------------------------------------------------
// fourth_power_phase_estimator_top_tb
// Streams sample frames through the estimator under random flow control and
// compares every frame result with an in-bench bit-accurate estimator.
// ----------------------------------------------------------------------------
module fourth_power_phase_estimator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fppe_pkg::*;

	localparam int  FRAME       = BLOCK_LEN;
	localparam int  DRAIN_WAIT  = 100;
	localparam int  HOLD_CYCLES = 8 * (BLOCK_LEN + 3);
	localparam longint CYCLE_LIMIT = 4000000;
	localparam longint ONE_Q30  = 64'sd1073741824;

	localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304
	};

	typedef struct {
		logic [31:0] m_cos;
		logic [31:0] m_sin;
		logic [30:0] amp;
		logic [15:0] ang;
	} frame_result_t;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	logic [7:0]          sample_byte;
	logic                empty;
	logic                pop;
	logic signed [31:0]  mean_cos;
	logic signed [31:0]  mean_sin;
	logic [30:0]         amplitude;
	logic signed [15:0]  phase_angle;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	fourth_power_phase_estimator_top u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.sample_byte(sample_byte), .empty(empty), .pop(pop),
		.mean_cos(mean_cos), .mean_sin(mean_sin), .amplitude(amplitude),
		.phase_angle(phase_angle), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	// estimator state
	logic [PHASE_BITS-1:0] est_step;
	int                    est_count;
	logic [PHASE_BITS-1:0] est_phase;
	longint                win_re [8];
	longint                win_im [8];
	longint                acc_cos;
	longint                acc_sin;
	frame_result_t         pending_results [$];

	int     errors;
	longint cycles;
	bit     calm;
	bit     hold_req;
	int     hold_left;
	int     stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("fourth_power_phase_estimator_top test failed");
			$finish;
		end
	end

	function automatic longint rnd_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	task automatic osc_trig(input logic [PHASE_BITS-1:0] ph, output longint c, output longint s);
		logic [31:0] u;
		bit          flip;
		longint      x, y, z, dx, dy;
		u = {ph, {(32 - PHASE_BITS){1'b0}}};
		flip = 1'b0;
		x = 652032874;
		y = 0;
		if (u >= 32'h4000_0000 && u < 32'hC000_0000) begin
			flip = 1'b1;
			u = u - 32'h8000_0000;
		end
		z = longint'($signed(u));
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TURNS[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TURNS[i];
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = clip(rnd_shift(x, 15), -32768, 32767);
		s = clip(rnd_shift(y, 15), -32768, 32767);
	endtask

	task automatic shift_window(longint re, longint im);
		for (int i = 0; i < 7; i++) begin
			win_re[i] = win_re[i+1];
			win_im[i] = win_im[i+1];
		end
		win_re[7] = re;
		win_im[7] = im;
	endtask

	// 8-tap average, raised to the fourth power, into the 46-bit sums
	task automatic add_fourth_power();
		longint ar, ai, c2, s2, c4, s4;
		logic signed [SUM_W-1:0] t;
		ar = 0;
		ai = 0;
		for (int i = 0; i < 8; i++) begin
			ar += win_re[i];
			ai += win_im[i];
		end
		ar = (ar + 4) >>> 3;
		ai = (ai + 4) >>> 3;
		c2 = rnd_shift(ar * ar - ai * ai, 4);
		s2 = rnd_shift(2 * ar * ai, 4);
		c4 = clip(rnd_shift(c2 * c2 - s2 * s2, 30), -ONE_Q30, ONE_Q30);
		s4 = clip(rnd_shift(2 * c2 * s2, 30), -ONE_Q30, ONE_Q30);
		t = SUM_W'(acc_cos + c4);
		acc_cos = t;
		t = SUM_W'(acc_sin + s4);
		acc_sin = t;
	endtask

	function automatic longint mean_of(longint s);
		longint m;
		if (s < 0)
			m = -((-s + FRAME / 2) / FRAME);
		else
			m = (s + FRAME / 2) / FRAME;
		return clip(m, -ONE_Q30, ONE_Q30);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] angle_of(longint x, longint y);
		logic [31:0] z;
		longint      dx, dy;
		z = 0;
		if (x == 0 && y == 0)
			return 16'd0;
		if (x < 0) begin
			x = -x; y = -y; z = 32'h8000_0000;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += 32'(ATAN_TURNS[i]);
			end else begin
				x -= dx; y += dy; z -= 32'(ATAN_TURNS[i]);
			end
		end
		return 16'((z + 32'h8000) >> 16);
	endfunction

	task automatic estimator_reset();
		est_step = STEP_RESET;
		est_count = 0;
		est_phase = '0;
		acc_cos = 0;
		acc_sin = 0;
		for (int i = 0; i < 8; i++) begin
			win_re[i] = 0;
			win_im[i] = 0;
		end
	endtask

	task automatic estimator_take(logic [7:0] b);
		longint        lev, cs, sn, re, im, mc, ms;
		frame_result_t r;
		case (b[3:2])
			2'd0:    lev = 10922;
			2'd1:    lev = -32768;
			2'd2:    lev = -10922;
			default: lev = 32767;
		endcase
		osc_trig(est_phase, cs, sn);
		re = clip(rnd_shift(lev * cs, 13), -131072, 131071);
		im = clip(rnd_shift(lev * sn, 13), -131072, 131071);
		if (est_count == 0) begin
			for (int i = 0; i < 8; i++) begin
				win_re[i] = re;
				win_im[i] = im;
			end
		end else begin
			shift_window(re, im);
		end
		if (est_count >= 3)
			add_fourth_power();
		est_phase = est_phase + est_step;
		est_count++;
		if (est_count < FRAME)
			return;
		// right-edge clamp for the last three averages
		for (int i = 0; i < 3; i++) begin
			shift_window(re, im);
			add_fourth_power();
		end
		mc = mean_of(acc_cos);
		ms = mean_of(acc_sin);
		r.m_cos = 32'(mc);
		r.m_sin = 32'(ms);
		r.amp = 31'(int_sqrt(longint'(mc * mc) + longint'(ms * ms)));
		r.ang = angle_of(mc, ms);
		pending_results.push_back(r);
		est_count = 0;
		est_phase = '0;
		acc_cos = 0;
		acc_sin = 0;
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// result side
	always @(posedge clk) begin
		frame_result_t r;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat", 32'(mean_cos), 32'd0);
			end else begin
				r = pending_results.pop_front();
				if (mean_cos !== r.m_cos)
					report_mismatch("mean_cos", mean_cos, r.m_cos);
				if (mean_sin !== r.m_sin)
					report_mismatch("mean_sin", mean_sin, r.m_sin);
				if (amplitude !== r.amp)
					report_mismatch("amplitude", 32'(amplitude), 32'(r.amp));
				if (phase_angle !== r.ang)
					report_mismatch("phase_angle", 32'(phase_angle), 32'(r.ang));
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// called at a falling edge; returns at a falling edge with push still high
	task automatic send_sample(logic [7:0] b);
		push <= 1'b1;
		sample_byte <= b;
		do
			@(posedge clk);
		while (full);
		estimator_take(b);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		if (!calm && $urandom_range(0, 31) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	task automatic send_frame(bit fixed, logic [7:0] b);
		for (int i = est_count; i < FRAME; i++) begin
			send_sample(fixed ? b : 8'($urandom));
			sender_gap();
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic apb_access(bit wr, logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_PHASE_STEP;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (!wr && prdata[PHASE_BITS-1:0] !== est_step)
			report_mismatch("phase_step readback", prdata, 32'(est_step));
		if (wr)
			est_step = data[PHASE_BITS-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_phase_step(logic [PHASE_BITS-1:0] v);
		wait_drained();
		apb_access(1'b1, 32'(v));
		apb_access(1'b0, '0);
	endtask

	task automatic test_field_extremes();
		logic [7:0] seq [$];
		apb_access(1'b0, '0);
		seq = '{8'h00, 8'hFF, 8'h04, 8'h08, 8'h0C, 8'hF3, 8'h55, 8'hAA, 8'hF0,
			8'h0F, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h33, 8'hCC};
		foreach (seq[i]) begin
			send_sample(seq[i]);
			sender_gap();
		end
		send_frame(1'b0, 8'h00);
	endtask

	task automatic test_constant_levels();
		set_phase_step('0);
		for (int l = 0; l < 4; l++)
			send_frame(1'b1, 8'({l[1:0], 2'b00}) | 8'(l * 16'h1111 & 16'hF3));
	endtask

	task automatic test_step_extremes();
		set_phase_step({PHASE_BITS{1'b1}});
		send_frame(1'b0, 8'h00);
		set_phase_step(PHASE_BITS'(BLOCK_LEN / 2));
		send_frame(1'b1, 8'h0C);
		set_phase_step(PHASE_BITS'(BLOCK_LEN / 4));
		send_frame(1'b1, 8'h0C);
	endtask

	// result register, back end, two queue entries and the stalled pipeline
	// fill with five frames; the sixth keeps offering samples against full
	task automatic test_output_backpressure();
		wait_drained();
		@(posedge clk);
		hold_req = 1'b1;
		@(negedge clk);
		for (int f = 0; f < 6; f++)
			send_frame(1'b0, 8'h00);
	endtask

	task automatic test_random_frames(int n);
		for (int f = 0; f < n; f++) begin
			if ($urandom_range(0, 2) == 0)
				set_phase_step(PHASE_BITS'($urandom));
			send_frame(1'b0, 8'h00);
		end
	endtask

	task automatic test_unbroken_stream();
		set_phase_step(STEP_RESET);
		calm = 1'b1;
		for (int f = 0; f < 3; f++)
			send_frame(1'b0, 8'h00);
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		stall_left = 0;
		arst_n = 1'b0;
		push = 1'b0;
		sample_byte = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		estimator_reset();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_field_extremes();
		test_constant_levels();
		test_step_extremes();
		test_output_backpressure();
		test_random_frames(16);
		test_unbroken_stream();

		wait_drained();
		if (errors == 0)
			$display("fourth_power_phase_estimator_top test passed");
		else
			$display("fourth_power_phase_estimator_top test failed");
		$finish;
	end

endmodule
